FILE: src/suart_pkg.sv
package suart_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_PUSH = 2'd1,
    FUNC_POP  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    TX_END   = 3'd0,
    TX_DELAY = 3'd1,
    TX_START = 3'd2,
    TX_DATA  = 3'd3,
    TX_STOP  = 3'd4
  } tx_phase_e;

  typedef enum logic [1:0] {
    RX_WAIT = 2'd0,
    RX_DATA = 2'd1,
    RX_STOP = 2'd2
  } rx_phase_e;

  localparam logic [2:0] BitTicks      = 3'd4;
  localparam logic [2:0] TxStopTicks   = 3'd3;
  localparam logic [2:0] RxFirstTicks  = 3'd5;
  localparam logic [2:0] RxStopTicks   = 3'd1;
  localparam logic [3:0] DataBits      = 4'd8;

  typedef struct packed {
    logic [1:0] func;
    logic       rx_line;
    logic [7:0] tx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_line;
    logic [7:0] rx_byte;
    logic [1:0] status;
    logic [4:0] rx_level;
    logic [4:0] tx_level;
    logic       tx_has_room;
  } out_item_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } fifo_req_t;

  typedef struct packed {
    logic tick;
    logic start;
    logic active;
  } tx_ctrl_t;

endpackage

FILE: src/soft_uart_oversampled_txrx.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid_i / in_stall_o | in_data_i (func, rx_line, tx_byte)
// out     | output    | out_valid_o / out_stall_i | out_data_o (line, byte, status, levels)
// one word in, one word out; a new word is taken every cycle unless a stall on the output holds it
// a word passes the input register, then the fifo/fsm update into the result register
// fifo head words sit in registered memory read ports addressed by the next head
// reset clears all control state; fifo contents are not cleared
// a stall on the output holds the result and, once the input register is full, the input
module soft_uart_oversampled_txrx #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  suart_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output suart_pkg::out_item_t out_data_o
);

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  logic                 in_valid_q, in_valid_d;
  suart_pkg::in_item_t  in_q;
  logic                 out_valid_q, out_valid_d;
  suart_pkg::out_item_t out_q, out_d;

  logic out_free, fire, accept;
  logic is_tick, is_push, is_pop;
  logic push_ok, pop_ok, tx_full;

  suart_pkg::fifo_req_t tx_req, rx_req;
  suart_pkg::tx_ctrl_t  tx_ctrl;
  logic [7:0]    tx_head, rx_head;
  logic [CW-1:0] tx_count, tx_count_next, rx_count, rx_count_next;
  logic          tx_line, tx_pop;
  logic          rx_push;
  logic [7:0]    rx_word;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_tick = fire && (in_q.func == suart_pkg::FUNC_TICK);
  assign is_push = fire && (in_q.func == suart_pkg::FUNC_PUSH);
  assign is_pop  = fire && (in_q.func == suart_pkg::FUNC_POP);

  assign tx_full = (tx_count == CW'(FIFO_DEPTH));
  assign push_ok = is_push && !tx_full;
  assign pop_ok  = is_pop && (rx_count != '0);

  assign tx_ctrl.tick   = is_tick;
  assign tx_ctrl.start  = push_ok && (tx_count == '0);
  assign tx_ctrl.active = (tx_count != '0);

  assign tx_req.push = push_ok;
  assign tx_req.pop  = tx_pop;
  assign tx_req.data = in_q.tx_byte;

  assign rx_req.push = rx_push;
  assign rx_req.pop  = pop_ok;
  assign rx_req.data = rx_word;

  suart_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (tx_req),
    .head_o       (tx_head),
    .count_o      (tx_count),
    .count_next_o (tx_count_next)
  );

  suart_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (rx_req),
    .head_o       (rx_head),
    .count_o      (rx_count),
    .count_next_o (rx_count_next)
  );

  suart_tx u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (tx_ctrl),
    .head_byte_i (tx_head),
    .line_o      (tx_line),
    .pop_o       (tx_pop)
  );

  suart_rx u_rx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (is_tick),
    .line_i (in_q.rx_line),
    .full_i (rx_count == CW'(FIFO_DEPTH)),
    .push_o (rx_push),
    .byte_o (rx_word)
  );

  always_comb begin
    out_d             = out_q;
    out_d.tx_line     = tx_line;
    out_d.rx_byte     = pop_ok ? rx_head : 8'd0;
    out_d.status      = suart_pkg::STATUS_OK;
    if (is_push && tx_full) begin
      out_d.status = suart_pkg::STATUS_FULL;
    end else if (is_pop && !pop_ok) begin
      out_d.status = suart_pkg::STATUS_EMPTY;
    end
    out_d.rx_level    = 5'(rx_count_next);
    out_d.tx_level    = 5'(tx_count_next);
    out_d.tx_has_room = (tx_count_next != CW'(FIFO_DEPTH));
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/suart_fifo.sv
module suart_fifo #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  suart_pkg::fifo_req_t req_i,
  output logic [7:0]          head_o,
  output logic [CW-1:0]       count_o,
  output logic [CW-1:0]       count_next_o
);

  logic [7:0]    mem_q [DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW:0]   wr_sum;
  logic [AW-1:0] wr_addr;

  // write slot is head plus count, wrapped once
  always_comb begin
    wr_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
    if (wr_sum >= (CW+1)'(DEPTH)) begin
      wr_addr = AW'(wr_sum - (CW+1)'(DEPTH));
    end else begin
      wr_addr = AW'(wr_sum);
    end
  end

  always_comb begin
    head_d = head_q;
    if (req_i.pop) begin
      head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
    end
    count_d = count_q + CW'(req_i.push) - CW'(req_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // read port follows the next head, so the registered word is always the current head
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[wr_addr] <= req_i.data;
    end
    if (req_i.push && (wr_addr == head_d)) begin
      rdata_q <= req_i.data;
    end else begin
      rdata_q <= mem_q[head_d];
    end
  end

  assign head_o       = rdata_q;
  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

FILE: src/suart_tx.sv
module suart_tx (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  suart_pkg::tx_ctrl_t ctrl_i,
  input  logic [7:0]         head_byte_i,
  output logic               line_o,
  output logic               pop_o
);

  suart_pkg::tx_phase_e phase_q, phase_d;
  logic [2:0] tick_q, tick_d;
  logic [3:0] bit_q, bit_d;
  logic       line_q, line_d;
  logic [2:0] tick_dec;

  assign tick_dec = tick_q - 3'd1;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    line_d  = line_q;
    pop_o   = 1'b0;
    if (ctrl_i.start) begin
      // first word into an empty queue: idle delay before the start bit
      tick_d  = suart_pkg::BitTicks;
      phase_d = suart_pkg::TX_DELAY;
    end else if (ctrl_i.tick && ctrl_i.active) begin
      unique case (phase_q)
        suart_pkg::TX_DELAY: begin
          tick_d = tick_dec;
          if (tick_dec != 3'd0) begin
            line_d = 1'b1;
          end else begin
            tick_d  = suart_pkg::BitTicks;
            phase_d = suart_pkg::TX_START;
          end
        end
        suart_pkg::TX_START: begin
          tick_d = tick_dec;
          if (tick_dec != 3'd0) begin
            line_d = 1'b0;
          end else begin
            bit_d   = '0;
            tick_d  = suart_pkg::BitTicks;
            phase_d = suart_pkg::TX_DATA;
          end
        end
        suart_pkg::TX_DATA: begin
          tick_d = tick_dec;
          if (tick_dec != 3'd0) begin
            if (bit_q < suart_pkg::DataBits) begin
              line_d = head_byte_i[bit_q[2:0]];
            end else begin
              line_d  = 1'b1;
              tick_d  = suart_pkg::TxStopTicks;
              phase_d = suart_pkg::TX_STOP;
            end
          end else begin
            bit_d  = bit_q + 4'd1;
            tick_d = suart_pkg::BitTicks;
          end
        end
        suart_pkg::TX_STOP: begin
          tick_d = tick_dec;
          if (tick_dec != 3'd0) begin
            line_d = 1'b1;
          end else begin
            pop_o   = 1'b1;
            tick_d  = suart_pkg::BitTicks;
            phase_d = suart_pkg::TX_START;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= suart_pkg::TX_END;
      tick_q  <= '0;
      bit_q   <= '0;
      line_q  <= 1'b1;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      line_q  <= line_d;
    end
  end

  assign line_o = line_d;

endmodule

FILE: src/suart_rx.sv
module suart_rx (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tick_i,
  input  logic       line_i,
  input  logic       full_i,
  output logic       push_o,
  output logic [7:0] byte_o
);

  suart_pkg::rx_phase_e phase_q, phase_d;
  logic [2:0] tick_q, tick_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [2:0] tick_dec;

  assign tick_dec = tick_q - 3'd1;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    push_o  = 1'b0;
    if (tick_i) begin
      unique case (phase_q)
        suart_pkg::RX_WAIT: begin
          if (!line_i) begin
            bit_d   = '0;
            shift_d = '0;
            tick_d  = suart_pkg::RxFirstTicks;
            phase_d = suart_pkg::RX_DATA;
          end
        end
        suart_pkg::RX_DATA: begin
          tick_d = tick_dec;
          if (tick_dec == 3'd0) begin
            if (line_i && (bit_q < suart_pkg::DataBits)) begin
              shift_d[bit_q[2:0]] = 1'b1;
            end
            bit_d = bit_q + 4'd1;
            // ninth sample is the stop-side slot and is thrown away
            if (bit_d > suart_pkg::DataBits) begin
              tick_d  = suart_pkg::RxStopTicks;
              phase_d = suart_pkg::RX_STOP;
            end else begin
              tick_d = suart_pkg::BitTicks;
            end
          end
        end
        suart_pkg::RX_STOP: begin
          tick_d = tick_dec;
          if (tick_dec == 3'd0) begin
            push_o  = line_i && !full_i;
            phase_d = suart_pkg::RX_WAIT;
          end
        end
        default: begin
          phase_d = suart_pkg::RX_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= suart_pkg::RX_WAIT;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
    end
  end

  assign byte_o = shift_q;

endmodule

FILE: dv/tb_soft_uart_oversampled_txrx.sv
`timescale 1ns / 1ps

module tb_soft_uart_oversampled_txrx;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned FifoDepth     = 16;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned MaxReported   = 10;

  localparam logic [1:0] FuncUnused = 2'd3;

  // rx line stimulus mixes and frame kinds
  localparam int unsigned MixClean     = 0;
  localparam int unsigned MixNormal    = 1;
  localparam int unsigned MixNoisy     = 2;
  localparam int unsigned KindBadStop  = 8;
  localparam int unsigned KindNoise    = 9;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  suart_pkg::in_item_t  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  suart_pkg::out_item_t out_data_o;

  soft_uart_oversampled_txrx #(
    .FIFO_DEPTH(FifoDepth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // predicted transceiver state
  suart_pkg::tx_phase_e pred_tx_phase = suart_pkg::TX_END;
  logic [2:0]  pred_tx_ticks = '0;
  logic [3:0]  pred_tx_bit   = '0;
  logic        pred_tx_line  = 1'b1;
  logic [7:0]  pred_tx_fifo [FifoDepth];
  int unsigned pred_tx_count = 0;
  int unsigned pred_tx_head  = 0;
  suart_pkg::rx_phase_e pred_rx_phase = suart_pkg::RX_WAIT;
  logic [2:0]  pred_rx_ticks = '0;
  logic [3:0]  pred_rx_bit   = '0;
  logic [7:0]  pred_rx_shift = '0;
  logic [7:0]  pred_rx_fifo [FifoDepth];
  int unsigned pred_rx_count = 0;
  int unsigned pred_rx_head  = 0;

  suart_pkg::out_item_t pending_responses [$];
  logic        rx_wave [$];
  int unsigned mismatches    = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_requests = 0;
  int unsigned idle_cycles   = 0;

  function automatic void tx_advance();
    if (pred_tx_count == 0 || pred_tx_phase == suart_pkg::TX_END) return;
    pred_tx_ticks = pred_tx_ticks - 3'd1;
    case (pred_tx_phase)
      suart_pkg::TX_DELAY: begin
        if (pred_tx_ticks != 0) begin
          pred_tx_line = 1'b1;
        end else begin
          pred_tx_ticks = suart_pkg::BitTicks;
          pred_tx_phase = suart_pkg::TX_START;
        end
      end
      suart_pkg::TX_START: begin
        if (pred_tx_ticks != 0) begin
          pred_tx_line = 1'b0;
        end else begin
          pred_tx_bit   = '0;
          pred_tx_ticks = suart_pkg::BitTicks;
          pred_tx_phase = suart_pkg::TX_DATA;
        end
      end
      suart_pkg::TX_DATA: begin
        if (pred_tx_ticks != 0) begin
          if (pred_tx_bit < suart_pkg::DataBits) begin
            pred_tx_line = pred_tx_fifo[pred_tx_head][pred_tx_bit[2:0]];
          end else begin
            pred_tx_line  = 1'b1;
            pred_tx_ticks = suart_pkg::TxStopTicks;
            pred_tx_phase = suart_pkg::TX_STOP;
          end
        end else begin
          pred_tx_bit   = pred_tx_bit + 4'd1;
          pred_tx_ticks = suart_pkg::BitTicks;
        end
      end
      suart_pkg::TX_STOP: begin
        if (pred_tx_ticks != 0) begin
          pred_tx_line = 1'b1;
        end else begin
          pred_tx_head  = (pred_tx_head + 1) % FifoDepth;
          pred_tx_count = pred_tx_count - 1;
          pred_tx_ticks = suart_pkg::BitTicks;
          pred_tx_phase = suart_pkg::TX_START;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void rx_sample(logic line);
    case (pred_rx_phase)
      suart_pkg::RX_WAIT: begin
        if (!line) begin
          pred_rx_bit   = '0;
          pred_rx_shift = '0;
          pred_rx_ticks = suart_pkg::RxFirstTicks;
          pred_rx_phase = suart_pkg::RX_DATA;
        end
      end
      suart_pkg::RX_DATA: begin
        pred_rx_ticks = pred_rx_ticks - 3'd1;
        if (pred_rx_ticks == 0) begin
          if (line && pred_rx_bit < suart_pkg::DataBits) begin
            pred_rx_shift[pred_rx_bit[2:0]] = 1'b1;
          end
          pred_rx_bit = pred_rx_bit + 4'd1;
          // ninth sample falls in the stop bit and is thrown away
          if (pred_rx_bit > suart_pkg::DataBits) begin
            pred_rx_ticks = suart_pkg::RxStopTicks;
            pred_rx_phase = suart_pkg::RX_STOP;
          end else begin
            pred_rx_ticks = suart_pkg::BitTicks;
          end
        end
      end
      suart_pkg::RX_STOP: begin
        pred_rx_ticks = pred_rx_ticks - 3'd1;
        if (pred_rx_ticks == 0) begin
          if (line && pred_rx_count < FifoDepth) begin
            pred_rx_fifo[(pred_rx_head + pred_rx_count) % FifoDepth] = pred_rx_shift;
            pred_rx_count = pred_rx_count + 1;
          end
          pred_rx_phase = suart_pkg::RX_WAIT;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic suart_pkg::out_item_t uart_response(suart_pkg::in_item_t w);
    suart_pkg::out_item_t r;
    r = '0;
    case (w.func)
      suart_pkg::FUNC_TICK: begin
        tx_advance();
        rx_sample(w.rx_line);
      end
      suart_pkg::FUNC_PUSH: begin
        if (pred_tx_count >= FifoDepth) begin
          r.status = suart_pkg::STATUS_FULL;
        end else begin
          if (pred_tx_count == 0) begin
            pred_tx_ticks = suart_pkg::BitTicks;
            pred_tx_phase = suart_pkg::TX_DELAY;
          end
          pred_tx_fifo[(pred_tx_head + pred_tx_count) % FifoDepth] = w.tx_byte;
          pred_tx_count = pred_tx_count + 1;
        end
      end
      suart_pkg::FUNC_POP: begin
        if (pred_rx_count == 0) begin
          r.status = suart_pkg::STATUS_EMPTY;
        end else begin
          r.rx_byte     = pred_rx_fifo[pred_rx_head];
          pred_rx_head  = (pred_rx_head + 1) % FifoDepth;
          pred_rx_count = pred_rx_count - 1;
        end
      end
      default: ;
    endcase
    r.tx_line     = pred_tx_line;
    r.rx_level    = 5'(pred_rx_count);
    r.tx_level    = 5'(pred_tx_count);
    r.tx_has_room = (pred_tx_count < FifoDepth);
    return r;
  endfunction

  function automatic suart_pkg::in_item_t make_word(logic [1:0] func, logic line,
                                                    logic [7:0] data);
    suart_pkg::in_item_t w;
    w.func    = func;
    w.rx_line = line;
    w.tx_byte = data;
    return w;
  endfunction

  // level of the rx line for the next tick, refilled frame by frame
  function automatic logic next_rx_level(int unsigned mix);
    int unsigned kind;
    logic [7:0]  data;
    if (rx_wave.size() == 0) begin
      kind = $urandom_range(0, 9);
      if (mix == MixClean) kind = 0;
      else if (mix == MixNoisy && kind < 5) kind = kind + 5;
      case ($urandom_range(0, 5))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        default: data = 8'($urandom);
      endcase
      repeat ($urandom_range(0, 3)) rx_wave.push_back(1'b1);
      if (kind == KindNoise) begin
        repeat ($urandom_range(1, 12)) rx_wave.push_back(1'($urandom));
      end else begin
        repeat (suart_pkg::BitTicks) rx_wave.push_back(1'b0);
        for (int i = 0; i < suart_pkg::DataBits; i++) begin
          repeat (suart_pkg::BitTicks) rx_wave.push_back(data[i]);
        end
        repeat (suart_pkg::BitTicks) rx_wave.push_back(kind != KindBadStop);
        if (kind == KindBadStop) repeat (2 * suart_pkg::BitTicks) rx_wave.push_back(1'b1);
      end
    end
    return rx_wave.pop_front();
  endfunction

  // offer one word in bursts with random gaps, predict on acceptance
  task automatic send_word(input suart_pkg::in_item_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    pending_responses.push_back(uart_response(w));
  endtask

  task automatic run_traffic(int unsigned count, int unsigned push_pct, int unsigned pop_pct,
                             int unsigned mix);
    suart_pkg::in_item_t w;
    int unsigned         pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      w    = make_word(suart_pkg::FUNC_TICK, 1'($urandom), 8'($urandom));
      if (pick < push_pct) w.func = suart_pkg::FUNC_PUSH;
      else if (pick < push_pct + pop_pct) w.func = suart_pkg::FUNC_POP;
      else if (pick < push_pct + pop_pct + 1) w.func = FuncUnused;
      else w.rx_line = next_rx_level(mix);
      send_word(w);
    end
  endtask

  task automatic test_directed_edges();
    send_word(make_word(suart_pkg::FUNC_POP, 1'b0, 8'h00));
    send_word(make_word(FuncUnused, 1'b1, 8'hFF));
    send_word(make_word(FuncUnused, 1'b0, 8'h00));
    send_word(make_word(suart_pkg::FUNC_TICK, 1'b1, 8'hFF));
    send_word(make_word(suart_pkg::FUNC_PUSH, 1'b1, 8'h00));
    send_word(make_word(suart_pkg::FUNC_PUSH, 1'b0, 8'hFF));
    repeat (FifoDepth - 2) begin
      send_word(make_word(suart_pkg::FUNC_PUSH, 1'($urandom), 8'($urandom)));
    end
    // tx fifo is full now, both pushes get refused
    send_word(make_word(suart_pkg::FUNC_PUSH, 1'b0, 8'h5A));
    send_word(make_word(suart_pkg::FUNC_PUSH, 1'b1, 8'hFF));
    send_word(make_word(suart_pkg::FUNC_POP, 1'b1, 8'hFF));
  endtask

  // no pops, clean frames: rx fifo overflows while the tx fifo drains
  task automatic test_rx_overflow();
    run_traffic(800, 0, 0, MixClean);
  endtask

  task automatic test_rx_drain();
    while (pred_rx_count != 0) begin
      send_word(make_word(suart_pkg::FUNC_POP, 1'($urandom), 8'($urandom)));
    end
    send_word(make_word(suart_pkg::FUNC_POP, 1'($urandom), 8'($urandom)));
  endtask

  task automatic test_mixed_traffic();
    run_traffic(500, 6, 5, MixNormal);
  endtask

  task automatic test_tx_overflow();
    repeat (FifoDepth + 2) begin
      send_word(make_word(suart_pkg::FUNC_PUSH, 1'($urandom), 8'($urandom)));
    end
    run_traffic(250, 2, 8, MixNormal);
  endtask

  task automatic test_output_hold_off();
    hold_requests <= hold_requests + 1;
    run_traffic(60, 10, 10, MixNormal);
  endtask

  task automatic test_noisy_line();
    run_traffic(200, 5, 5, MixNoisy);
  endtask

  task automatic check_field(string field, int unsigned expected, int unsigned actual);
    if (expected != actual) begin
      mismatches++;
      if (mismatches <= MaxReported)
        $display("mismatch %s: expected 0x%0h, got 0x%0h", field, expected, actual);
    end
  endtask

  always @(posedge clk_i) begin
    suart_pkg::out_item_t exp_word;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected word 0x%0h with nothing pending", out_data_o);
      end else begin
        exp_word = pending_responses.pop_front();
        check_field("tx_line", 32'(exp_word.tx_line), 32'(out_data_o.tx_line));
        check_field("rx_byte", 32'(exp_word.rx_byte), 32'(out_data_o.rx_byte));
        check_field("status", 32'(exp_word.status), 32'(out_data_o.status));
        check_field("rx_level", 32'(exp_word.rx_level), 32'(out_data_o.rx_level));
        check_field("tx_level", 32'(exp_word.tx_level), 32'(out_data_o.tx_level));
        check_field("tx_has_room", 32'(exp_word.tx_has_room),
                    32'(out_data_o.tx_has_room));
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin : stall_pattern
    int unsigned pattern_left;
    int unsigned stall_pct;
    int unsigned hold_left;
    int unsigned holds_done;
    out_stall_i  = 1'b0;
    pattern_left = 0;
    stall_pct    = 0;
    hold_left    = 0;
    holds_done   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_done != hold_requests) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      pattern_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_rx_overflow();
    test_rx_drain();
    test_mixed_traffic();
    test_tx_overflow();
    test_output_hold_off();
    test_noisy_line();

    in_valid_i <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
